FILE: src/rope_pkg.sv
// ----------------------------------------------------------------------------
// rope_pkg
// Shared types and constants of the rotary position embedding block.
// ----------------------------------------------------------------------------
package rope_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int TRIG_BITS   = 16;
  localparam int INDEX_BITS  = 7;
  localparam int POS_BITS    = 10;
  localparam int FREQ_BITS   = 6;
  localparam int HALF_BITS   = 7;
  localparam int CFG_BITS    = 7;
  localparam int CFG_IDX_BITS = 1;
  localparam int PROD_BITS   = SAMPLE_BITS + TRIG_BITS;
  localparam int FRAC_BITS   = 15;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [TRIG_BITS-1:0]   trig_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic [INDEX_BITS-1:0]         index_t;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_ROTATE = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_NEOX_LAYOUT = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_DIM    = 1'b1;

  // control that travels alongside the sample data through the pipeline
  typedef struct packed {
    logic   valid;
    logic   range_err;
    index_t idx_a;
    index_t idx_b;
  } rope_ctrl_t;

endpackage

FILE: src/rotary_position_embedding.sv
// ----------------------------------------------------------------------------
// rotary_position_embedding
// Rotary position embedding of one head element pair per transfer.
// ----------------------------------------------------------------------------
// Input channel (in_*): a load command writes sin (value_a) and cos (value_b)
// into the table entry of (position, freq_index) and gives no result. A
// rotate command looks up that entry and yields one result transfer on the
// out_* channel with the rotated pair, its element indices and a range flag.
// Configuration (cfg_*) sets the pair layout and the half head dimension;
// write it only while no rotate is in flight.
// A rotate passes the input register and table read, the product stage
// and the output register. Throughput: one item per cycle unless stalled,
// set by the single port of the sin/cos table RAM (one load or one lookup
// per cycle). The pipeline stages advance together; while a result waits
// under out_stall the whole pipeline holds and in_stall is raised.
// Reset clears the pipeline valids and restores the configuration defaults;
// the tables are not cleared and hold undefined data until loaded.
// ----------------------------------------------------------------------------
module rotary_position_embedding #(
  parameter int MAX_POSITIONS = 1024,
  parameter int MAX_HALF_DIM  = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_command,
  input  logic [rope_pkg::POS_BITS-1:0]        in_position,
  input  logic [rope_pkg::FREQ_BITS-1:0]       in_freq_index,
  input  rope_pkg::sample_t                    in_value_a,
  input  rope_pkg::sample_t                    in_value_b,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output rope_pkg::sample_t                    out_rotated_a,
  output rope_pkg::sample_t                    out_rotated_b,
  output rope_pkg::index_t                     out_index_a,
  output rope_pkg::index_t                     out_index_b,
  output logic                                 out_range_error,
  input  logic                                 cfg_write_en,
  input  logic [rope_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [rope_pkg::CFG_BITS-1:0]        cfg_data
);
  import rope_pkg::*;

  localparam int DEPTH = MAX_POSITIONS * MAX_HALF_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int HW    = $clog2(MAX_HALF_DIM + 1);

  logic                 neox_r;
  logic [HALF_BITS-1:0] half_r;

  logic                 en;
  logic                 accept;
  logic                 range_err;
  logic                 load_ok;
  logic [HW-1:0]        half_eff;
  logic [AW-1:0]        addr;
  index_t               idx_a, idx_b;
  logic                 ram_en, ram_we;
  logic [2*TRIG_BITS-1:0] ram_rdata;

  rope_ctrl_t           ctrl1_r, ctrl1_nxt;
  sample_t              a1_r, b1_r;
  rope_ctrl_t           ctrl_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neox_r <= 1'b1;
      half_r <= HALF_BITS'(64);
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_NEOX_LAYOUT: neox_r <= cfg_data[0];
        CFG_HALF_DIM:    half_r <= cfg_data[HALF_BITS-1:0];
        default:         ;
      endcase
    end
  end

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;
  assign accept   = in_valid && en;

  always_comb begin
    if (half_r == '0) begin
      half_eff = HW'(1);
    end else if (32'(half_r) > MAX_HALF_DIM) begin
      half_eff = HW'(MAX_HALF_DIM);
    end else begin
      half_eff = HW'(half_r);
    end
    range_err = (32'(in_position) >= MAX_POSITIONS) ||
                (32'(in_freq_index) >= 32'(half_eff));
    load_ok   = (32'(in_position) < MAX_POSITIONS) &&
                (32'(in_freq_index) < MAX_HALF_DIM);
    addr      = AW'(32'(in_position) * MAX_HALF_DIM + 32'(in_freq_index));
    if (neox_r) begin
      idx_a = INDEX_BITS'(in_freq_index);
      idx_b = INDEX_BITS'(32'(in_freq_index) + 32'(half_eff));
    end else begin
      idx_a = INDEX_BITS'({in_freq_index, 1'b0});
      idx_b = INDEX_BITS'({in_freq_index, 1'b1});
    end
    ram_we = accept && (in_command == CMD_LOAD) && load_ok;
    ram_en = ram_we || (accept && (in_command == CMD_ROTATE) && !range_err);
    ctrl1_nxt.valid     = accept && (in_command == CMD_ROTATE);
    ctrl1_nxt.range_err = range_err;
    ctrl1_nxt.idx_a     = idx_a;
    ctrl1_nxt.idx_b     = idx_b;
  end

  rope_ram #(
    .WIDTH (2 * TRIG_BITS),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (addr),
    .wdata ({in_value_a, in_value_b}),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl1_r.valid <= 1'b0;
    end else if (en) begin
      ctrl1_r.valid     <= ctrl1_nxt.valid;
      ctrl1_r.range_err <= ctrl1_nxt.range_err;
      ctrl1_r.idx_a     <= ctrl1_nxt.idx_a;
      ctrl1_r.idx_b     <= ctrl1_nxt.idx_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r              <= in_value_a;
      b1_r              <= in_value_b;
    end
  end

  rope_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .ctrl_in   (ctrl1_r),
    .value_a   (a1_r),
    .value_b   (b1_r),
    .sin_val   (trig_t'(ram_rdata[2*TRIG_BITS-1:TRIG_BITS])),
    .cos_val   (trig_t'(ram_rdata[TRIG_BITS-1:0])),
    .ctrl_out  (ctrl_out),
    .rotated_a (out_rotated_a),
    .rotated_b (out_rotated_b)
  );

  assign out_valid       = ctrl_out.valid;
  assign out_index_a     = ctrl_out.idx_a;
  assign out_index_b     = ctrl_out.idx_b;
  assign out_range_error = ctrl_out.range_err;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled without a waiting result");

  a_err_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_error) |->
      (out_rotated_a == '0 && out_rotated_b == '0 &&
       out_index_a == '0 && out_index_b == '0))
    else $error("range error result carries nonzero fields");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_command == CMD_LOAD) |=> !ctrl1_r.valid)
    else $error("load transfer produced a pipeline entry");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> (ctrl1_r.valid == $past(ctrl1_r.valid)))
    else $error("pipeline advanced while stalled");

endmodule

FILE: src/rope_ram.sv
// ----------------------------------------------------------------------------
// rope_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module rope_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: src/rope_datapath.sv
// ----------------------------------------------------------------------------
// rope_datapath
// Rotation arithmetic: product stage, then sum, round, saturate and the
// output register.
// ----------------------------------------------------------------------------
module rope_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  rope_pkg::rope_ctrl_t ctrl_in,
  input  rope_pkg::sample_t    value_a,
  input  rope_pkg::sample_t    value_b,
  input  rope_pkg::trig_t      sin_val,
  input  rope_pkg::trig_t      cos_val,
  output rope_pkg::rope_ctrl_t ctrl_out,
  output rope_pkg::sample_t    rotated_a,
  output rope_pkg::sample_t    rotated_b
);
  import rope_pkg::*;

  localparam int ACC_BITS = PROD_BITS + 2;
  localparam int Q_BITS   = ACC_BITS - FRAC_BITS;
  localparam logic signed [Q_BITS-1:0] SAT_HI =
    Q_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [Q_BITS-1:0] SAT_LO =
    Q_BITS'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
  localparam logic signed [ACC_BITS-1:0] HALF_LSB =
    ACC_BITS'(64'sd1 <<< (FRAC_BITS - 1));

  rope_ctrl_t ctrl2_r;
  prod_t      prod_ac_r, prod_bs_r, prod_bc_r, prod_as_r;
  rope_ctrl_t ctrl3_r;
  sample_t    rot_a_r, rot_b_r;

  logic signed [ACC_BITS-1:0] acc_a, acc_b;
  sample_t                    rot_a_nxt, rot_b_nxt;

  function automatic sample_t round_sat(input logic signed [ACC_BITS-1:0] acc);
    logic signed [ACC_BITS-1:0] biased;
    logic signed [Q_BITS-1:0]   q;
    sample_t                    res;
    biased = acc + HALF_LSB;
    q = Q_BITS'(biased >>> FRAC_BITS);
    if (q > SAT_HI) begin
      res = SAT_HI[SAMPLE_BITS-1:0];
    end else if (q < SAT_LO) begin
      res = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      res = q[SAMPLE_BITS-1:0];
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl2_r.valid <= 1'b0;
      ctrl3_r.valid <= 1'b0;
    end else if (en) begin
      ctrl2_r.valid     <= ctrl_in.valid;
      ctrl3_r.valid     <= ctrl2_r.valid;
      ctrl2_r.range_err <= ctrl_in.range_err;
      ctrl2_r.idx_a     <= ctrl_in.idx_a;
      ctrl2_r.idx_b     <= ctrl_in.idx_b;
      ctrl3_r.range_err <= ctrl2_r.range_err;
      ctrl3_r.idx_a     <= ctrl2_r.range_err ? '0 : ctrl2_r.idx_a;
      ctrl3_r.idx_b     <= ctrl2_r.range_err ? '0 : ctrl2_r.idx_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_ac_r         <= value_a * cos_val;
      prod_bs_r         <= value_b * sin_val;
      prod_bc_r         <= value_b * cos_val;
      prod_as_r         <= value_a * sin_val;
      rot_a_r           <= rot_a_nxt;
      rot_b_r           <= rot_b_nxt;
    end
  end

  always_comb begin
    acc_a = ACC_BITS'(prod_ac_r) - ACC_BITS'(prod_bs_r);
    acc_b = ACC_BITS'(prod_bc_r) + ACC_BITS'(prod_as_r);
    rot_a_nxt = ctrl2_r.range_err ? '0 : round_sat(acc_a);
    rot_b_nxt = ctrl2_r.range_err ? '0 : round_sat(acc_b);
  end

  assign ctrl_out  = ctrl3_r;
  assign rotated_a = rot_a_r;
  assign rotated_b = rot_b_r;

endmodule

FILE: test/tb_rotary_position_embedding.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotary_position_embedding
// Self-checking bench for the rotary position embedding block.
// ----------------------------------------------------------------------------
// Fills the sin/cos tables with load transfers; in-range rotates only use
// loaded entries. A scoreboard keeps its own copy of the tables and registers,
// predicts each rotate result and checks the output transfers in order. The
// run steps through several layout and half dimension settings, including
// the clamped ones, with bursty input and a changing output stall pattern.
// ----------------------------------------------------------------------------

localparam int ROPE_ROWS     = 1024;
localparam int ROPE_HALF_MAX = 64;

typedef struct {
  rope_pkg::sample_t rotated_a;
  rope_pkg::sample_t rotated_b;
  rope_pkg::index_t  index_a;
  rope_pkg::index_t  index_b;
  logic              range_error;
} rope_result_t;

class rope_scoreboard;
  logic [15:0]  sine_q15   [ROPE_ROWS*ROPE_HALF_MAX];
  logic [15:0]  cosine_q15 [ROPE_ROWS*ROPE_HALF_MAX];
  bit           pair_split;
  int           half_raw;
  rope_result_t rotations_due[$];
  int           errors;
  int           checked;
  int           range_hits;

  function new();
    pair_split = 1'b1;
    half_raw   = 64;
    errors     = 0;
    checked    = 0;
    range_hits = 0;
  endfunction

  function void write_reg(logic [rope_pkg::CFG_IDX_BITS-1:0] idx,
                          logic [rope_pkg::CFG_BITS-1:0] data);
    if (idx == rope_pkg::CFG_NEOX_LAYOUT) begin
      pair_split = data[0];
    end else begin
      half_raw = int'(data);
    end
  endfunction

  function int half_eff();
    if (half_raw < 1) return 1;
    if (half_raw > ROPE_HALF_MAX) return ROPE_HALF_MAX;
    return half_raw;
  endfunction

  function rope_pkg::sample_t round_q15(longint acc);
    longint q;
    q = (acc + 64'sd16384) >>> 15;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return rope_pkg::sample_t'(q);
  endfunction

  function void note_input(logic cmd, logic [rope_pkg::POS_BITS-1:0] pos,
                           logic [rope_pkg::FREQ_BITS-1:0] j,
                           rope_pkg::sample_t a, rope_pkg::sample_t b);
    int           addr;
    int           h;
    longint       la, lb, ls, lc;
    rope_result_t r;
    addr = int'(pos) * ROPE_HALF_MAX + int'(j);
    if (cmd == rope_pkg::CMD_LOAD) begin
      sine_q15[addr]   = a;
      cosine_q15[addr] = b;
      return;
    end
    h = half_eff();
    r.rotated_a   = '0;
    r.rotated_b   = '0;
    r.index_a     = '0;
    r.index_b     = '0;
    r.range_error = 1'b0;
    if (int'(j) >= h) begin
      r.range_error = 1'b1;
      range_hits++;
    end else begin
      la = a;
      lb = b;
      ls = $signed(sine_q15[addr]);
      lc = $signed(cosine_q15[addr]);
      r.rotated_a = round_q15(la * lc - lb * ls);
      r.rotated_b = round_q15(lb * lc + la * ls);
      if (pair_split) begin
        r.index_a = rope_pkg::index_t'(int'(j));
        r.index_b = rope_pkg::index_t'(int'(j) + h);
      end else begin
        r.index_a = rope_pkg::index_t'(2 * int'(j));
        r.index_b = rope_pkg::index_t'(2 * int'(j) + 1);
      end
    end
    rotations_due.insert(rotations_due.size(), r);
  endfunction

  function void check_field(string name, logic signed [31:0] exp_v,
                            logic signed [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check_result(rope_pkg::sample_t ra, rope_pkg::sample_t rb,
                             rope_pkg::index_t ia, rope_pkg::index_t ib, logic err);
    rope_result_t e;
    if (rotations_due.size() == 0) begin
      $error("result transfer with no rotation outstanding");
      errors++;
      return;
    end
    e = rotations_due.pop_front();
    checked++;
    check_field("rotated_a", e.rotated_a, ra);
    check_field("rotated_b", e.rotated_b, rb);
    check_field("index_a", e.index_a, ia);
    check_field("index_b", e.index_b, ib);
    check_field("range_error", e.range_error, err);
  endfunction
endclass

module tb_rotary_position_embedding;

  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 120;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int RANDOM_ITEMS  = 100;
  localparam int NUM_PHASES    = 8;

  localparam rope_pkg::sample_t SMAX = 16'sh7FFF;
  localparam rope_pkg::sample_t SMIN = 16'sh8000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  logic                                clk             = 1'b0;
  logic                                rst_n           = 1'b0;
  logic                                in_valid        = 1'b0;
  logic                                in_stall;
  logic                                in_command      = rope_pkg::CMD_LOAD;
  logic [rope_pkg::POS_BITS-1:0]       in_position     = '0;
  logic [rope_pkg::FREQ_BITS-1:0]      in_freq_index   = '0;
  rope_pkg::sample_t                   in_value_a      = '0;
  rope_pkg::sample_t                   in_value_b      = '0;
  logic                                out_valid;
  logic                                out_stall       = 1'b0;
  rope_pkg::sample_t                   out_rotated_a;
  rope_pkg::sample_t                   out_rotated_b;
  rope_pkg::index_t                    out_index_a;
  rope_pkg::index_t                    out_index_b;
  logic                                out_range_error;
  logic                                cfg_write_en    = 1'b0;
  logic [rope_pkg::CFG_IDX_BITS-1:0]   cfg_index       = rope_pkg::CFG_NEOX_LAYOUT;
  logic [rope_pkg::CFG_BITS-1:0]       cfg_data        = '0;

  rope_scoreboard sb = new();

  bit          loaded [ROPE_ROWS*ROPE_HALF_MAX];
  int          loaded_addrs[$];
  int          cur_half     = 64;
  int          transfers_in = 0;
  int          settings     = 0;
  int          holds_done   = 0;
  bit          hold_req     = 1'b0;
  int          hold_left    = 0;
  stall_mode_t stall_mode   = STALL_NONE;
  int          mode_left    = 0;
  int          cycle_count  = 0;

  rotary_position_embedding u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_position     (in_position),
    .in_freq_index   (in_freq_index),
    .in_value_a      (in_value_a),
    .in_value_b      (in_value_b),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_rotated_a   (out_rotated_a),
    .out_rotated_b   (out_rotated_b),
    .out_index_a     (out_index_a),
    .out_index_b     (out_index_b),
    .out_range_error (out_range_error),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // output stall: long hold on request, otherwise a changing pattern
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      holds_done++;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(16, 96);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_LIGHT:  out_stall <= ($urandom_range(0, 99) < 30);
        STALL_HEAVY:  out_stall <= ($urandom_range(0, 99) < 70);
        default:      out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_rotated_a, out_rotated_b, out_index_a, out_index_b,
                      out_range_error);
    end
  end

  task automatic push_item(logic cmd, int pos, int j, rope_pkg::sample_t a,
                           rope_pkg::sample_t b);
    int addr;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_position   <= pos[rope_pkg::POS_BITS-1:0];
    in_freq_index <= j[rope_pkg::FREQ_BITS-1:0];
    in_value_a    <= a;
    in_value_b    <= b;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_input(cmd, pos[rope_pkg::POS_BITS-1:0], j[rope_pkg::FREQ_BITS-1:0], a, b);
    transfers_in++;
    addr = pos * ROPE_HALF_MAX + j;
    if (cmd == rope_pkg::CMD_LOAD && !loaded[addr]) begin
      loaded[addr] = 1'b1;
      loaded_addrs.insert(loaded_addrs.size(), addr);
    end
  endtask

  task automatic idle_input(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain();
    idle_input(1);
    while (sb.rotations_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [rope_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [rope_pkg::CFG_BITS-1:0] data);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    sb.write_reg(idx, data);
    cur_half = sb.half_eff();
  endtask

  function automatic rope_pkg::sample_t pick_sample();
    case ($urandom_range(0, 7))
      0:       return SMIN;
      1:       return SMAX;
      2:       return rope_pkg::sample_t'(int'($urandom_range(0, 2)) - 1);
      default: return rope_pkg::sample_t'($urandom);
    endcase
  endfunction

  task automatic send_random();
    int r;
    int start;
    int addr;
    int i;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      push_item(rope_pkg::CMD_LOAD, $urandom_range(0, ROPE_ROWS - 1),
                $urandom_range(0, ROPE_HALF_MAX - 1), pick_sample(), pick_sample());
      return;
    end
    if (r < 40 && cur_half < ROPE_HALF_MAX) begin
      push_item(rope_pkg::CMD_ROTATE, $urandom_range(0, ROPE_ROWS - 1),
                $urandom_range(cur_half, ROPE_HALF_MAX - 1), pick_sample(), pick_sample());
      return;
    end
    // rotate a loaded entry inside the active half, else load one inside it
    addr = -1;
    if (loaded_addrs.size() != 0) begin
      start = $urandom_range(0, loaded_addrs.size() - 1);
      for (i = 0; i < loaded_addrs.size(); i++) begin
        if ((loaded_addrs[(start + i) % loaded_addrs.size()] % ROPE_HALF_MAX) < cur_half) begin
          addr = loaded_addrs[(start + i) % loaded_addrs.size()];
          break;
        end
      end
    end
    if (addr < 0) begin
      push_item(rope_pkg::CMD_LOAD, $urandom_range(0, ROPE_ROWS - 1),
                $urandom_range(0, cur_half - 1), pick_sample(), pick_sample());
    end else begin
      push_item(rope_pkg::CMD_ROTATE, addr / ROPE_HALF_MAX, addr % ROPE_HALF_MAX,
                pick_sample(), pick_sample());
    end
  endtask

  task automatic run_random(int n_items, bit with_hold, bit with_pause);
    int burst;
    int k;
    burst = $urandom_range(1, 24);
    for (k = 0; k < n_items; k++) begin
      if (with_hold && k == n_items / 3) begin
        hold_req = 1'b1;
        burst = 40;
      end
      if (with_pause && k == n_items / 2) begin
        drain();
      end
      if (burst == 0) begin
        idle_input($urandom_range(1, 8));
        burst = $urandom_range(1, 32);
      end
      send_random();
      burst--;
    end
  endtask

  task automatic run_directed();
    push_item(rope_pkg::CMD_LOAD, 0, 0, 16'sd0, SMAX);
    push_item(rope_pkg::CMD_LOAD, 1023, 63, SMIN, SMIN);
    push_item(rope_pkg::CMD_LOAD, 512, 31, SMAX, 16'sd0);
    push_item(rope_pkg::CMD_LOAD, 1, 1, 16'sd16384, 16'sd16384);
    push_item(rope_pkg::CMD_LOAD, 2, 62, SMIN, SMAX);
    push_item(rope_pkg::CMD_ROTATE, 0, 0, SMAX, SMIN);
    push_item(rope_pkg::CMD_ROTATE, 0, 0, SMIN, SMAX);
    push_item(rope_pkg::CMD_ROTATE, 1023, 63, SMIN, SMIN);
    push_item(rope_pkg::CMD_ROTATE, 1023, 63, SMAX, SMIN);
    push_item(rope_pkg::CMD_ROTATE, 512, 31, 16'sd12345, -16'sd1);
    // rounding ties go toward plus infinity
    push_item(rope_pkg::CMD_ROTATE, 1, 1, 16'sd1, 16'sd0);
    push_item(rope_pkg::CMD_ROTATE, 1, 1, -16'sd1, 16'sd0);
    push_item(rope_pkg::CMD_ROTATE, 1, 1, 16'sd1, 16'sd1);
    push_item(rope_pkg::CMD_ROTATE, 2, 62, 16'sd0, 16'sd0);
    push_item(rope_pkg::CMD_ROTATE, 2, 62, SMAX, SMAX);
    push_item(rope_pkg::CMD_ROTATE, 2, 62, SMIN, SMIN);
  endtask

  initial begin
    int                          p;
    int                          layout [NUM_PHASES];
    int                          half   [NUM_PHASES];
    logic [rope_pkg::CFG_BITS-1:0] d;

    layout = '{1, 0, 1, 1, 0, 0, 1, 0};
    half   = '{64, 1, 0, 127, 64, 33, $urandom_range(2, 63), $urandom_range(65, 126)};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (p = 0; p < NUM_PHASES; p++) begin
      if (p == 0) begin
        run_directed();
      end else begin
        drain();
        d = rope_pkg::CFG_BITS'($urandom);
        d[0] = layout[p][0];
        write_reg(rope_pkg::CFG_NEOX_LAYOUT, d);
        write_reg(rope_pkg::CFG_HALF_DIM, rope_pkg::CFG_BITS'(half[p]));
        if (p == 1) begin
          push_item(rope_pkg::CMD_ROTATE, 1023, 63, SMAX, SMIN);
          push_item(rope_pkg::CMD_ROTATE, 5, 1, 16'sd7, 16'sd9);
          push_item(rope_pkg::CMD_ROTATE, 0, 0, SMAX, 16'sd3);
        end
      end
      settings++;
      run_random(RANDOM_ITEMS, p == 3, p == 5);
    end

    drain();
    $display("Rotations checked: %0d (%0d out of range) from %0d input transfers",
             sb.checked, sb.range_hits, transfers_in);
    $display("Register settings: %0d, both pair layouts, long output holds: %0d",
             settings, holds_done);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
